@@ sv/pgmb_pkg.sv @@
package pgmb_pkg;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] height;
    logic [7:0]         attr_three;
    logic [7:0]         attr_four;
    logic [7:0]         attr_five;
    logic [15:0]        read_index;
  } item_t;

  typedef struct packed {
    logic               point_accepted;
    logic [15:0]        cell_address;
    logic signed [31:0] mean_value;
    logic [15:0]        sample_count;
    logic               cell_empty;
  } result_t;

  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LOWER,
    REG_X_UPPER,
    REG_Y_LOWER,
    REG_Y_UPPER,
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_VALUE_COLUMN
  } reg_index_t;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [2:0] COL_HEIGHT     = 3'd2;
  localparam logic [2:0] COL_ATTR_THREE = 3'd3;
  localparam logic [2:0] COL_ATTR_FOUR  = 3'd4;
  localparam logic [2:0] COL_ATTR_FIVE  = 3'd5;

  localparam int GRID_N_W   = 13;
  localparam int DIV_W      = 50;
  localparam int DIV_STEP_W = 6;
  localparam int QUOT_W     = 32;
  localparam int MEM_W      = 48;

  localparam logic [DIV_STEP_W-1:0] INDEX_STEPS = 6'd13;
  localparam logic [DIV_STEP_W-1:0] MEAN_STEPS  = 6'd32;
  localparam logic [15:0]           COUNT_MAX   = 16'hFFFF;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEP_W-1:0] steps;
    logic [DIV_W-1:0]      dividend;
    logic [DIV_W-1:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_MUL,
    S_DIVX_GO,
    S_DIVX_WAIT,
    S_DIVY_GO,
    S_DIVY_WAIT,
    S_ADDR,
    S_READ,
    S_LATCH,
    S_PROD,
    S_SUM,
    S_DIVM_GO,
    S_DIVM_WAIT,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

@@ sv/pgmb_div.sv @@
module pgmb_div (
  input  logic               clk,
  input  logic               rst,
  input  pgmb_pkg::div_req_t req,
  output pgmb_pkg::div_rsp_t rsp
);
  import pgmb_pkg::*;

  logic [DIV_W-1:0]      rem;
  logic [DIV_W-1:0]      dsh;
  logic [QUOT_W-1:0]     quot;
  logic [DIV_STEP_W-1:0] left;
  logic                  busy;
  logic                  done;
  logic                  fits;

  // The caller hands in the divisor already aligned to the top quotient bit.
  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      left <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        left <= req.steps;
      end else if (busy) begin
        left <= left - 1'b1;
        if (left == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.dividend;
      dsh  <= req.divisor;
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      quot <= {quot[QUOT_W-2:0], fits};
      dsh  <= dsh >> 1;
    end
  end

  assign rsp = '{busy: busy, done: done, quotient: quot};

endmodule

@@ sv/pgmb_store.sv @@
module pgmb_store #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [pgmb_pkg::MEM_W-1:0] wdata,
  input  logic [AW-1:0]              raddr,
  output logic [pgmb_pkg::MEM_W-1:0] rdata
);
  import pgmb_pkg::*;

  logic [MEM_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/point_grid_mean_binning.sv @@
// An accepted add runs two 13-step index divisions and one 32-step mean division,
// all on the shared divider. A read skips the divisions (S_ADDR, S_READ, S_LATCH),
// and a rejected point goes from S_MUL straight to S_DONE. One item is in work at a
// time, so the next item is taken only after each result is loaded.
// Reset: synchronous; afterwards the cell store is cleared one entry per cycle
// (all MAX_COLUMNS*MAX_ROWS entries, 65536 by default) while item_stall stays high.
module point_grid_mean_binning #(
  parameter int MAX_COLUMNS = 256,
  parameter int MAX_ROWS    = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  pgmb_pkg::item_t                item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output pgmb_pkg::result_t              result,
  input  logic                           cfg_write,
  input  logic [pgmb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pgmb_pkg::CFG_W-1:0]     cfg_data
);
  import pgmb_pkg::*;

  localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int AFW   = 25;

  // Configuration registers.
  logic signed [31:0] x_lower, x_upper, y_lower, y_upper;
  logic [8:0]         grid_width, grid_height;
  logic [2:0]         value_column;

  always_ff @(posedge clk) begin
    if (rst) begin
      x_lower      <= 32'sd0;
      x_upper      <= 32'sd256;
      y_lower      <= 32'sd0;
      y_upper      <= 32'sd256;
      grid_width   <= 9'd256;
      grid_height  <= 9'd256;
      value_column <= COL_HEIGHT;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_X_LOWER:      x_lower      <= cfg_data;
        REG_X_UPPER:      x_upper      <= cfg_data;
        REG_Y_LOWER:      y_lower      <= cfg_data;
        REG_Y_UPPER:      y_upper      <= cfg_data;
        REG_GRID_WIDTH:   grid_width   <= cfg_data[8:0];
        REG_GRID_HEIGHT:  grid_height  <= cfg_data[8:0];
        REG_VALUE_COLUMN: value_column <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Grid sizes limited to the store's dimensions.
  logic [GRID_N_W-1:0] gw_ext, gh_ext, n_x, n_y;
  assign gw_ext = {4'b0, grid_width};
  assign gh_ext = {4'b0, grid_height};
  assign n_x = (gw_ext > GRID_N_W'(MAX_COLUMNS)) ? GRID_N_W'(MAX_COLUMNS) : gw_ext;
  assign n_y = (gh_ext > GRID_N_W'(MAX_ROWS)) ? GRID_N_W'(MAX_ROWS) : gh_ext;

  state_t state, state_next;

  item_t              cur;
  logic signed [32:0] diff_x, span_x, diff_y, span_y;
  logic signed [31:0] value;
  logic               value_ok;
  logic signed [46:0] num_x, num_y;
  logic [CW-1:0]      col;
  logic [RW-1:0]      row;
  logic [AFW-1:0]     addr_full;
  logic               addr_in;
  logic [15:0]        cnt, cnt_new;
  logic signed [31:0] mean, mean_new;
  logic signed [48:0] prod;
  logic [16:0]        den;
  logic               sum_neg;
  logic [DIV_W-1:0]   div_num;
  logic [AW-1:0]      clr_addr;
  result_t            res;

  logic               bin_ok;
  logic signed [49:0] sum;
  logic [DIV_W-1:0]   mag;
  logic               out_load;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [MEM_W-1:0]   mem_wdata, mem_rdata;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  // The product bounds reduce to diff < span once the grid size is nonzero.
  assign bin_ok = value_ok
                  && (span_x > 33'sd0) && (n_x != '0)
                  && (diff_x >= 33'sd0) && (diff_x < span_x)
                  && (span_y > 33'sd0) && (n_y != '0)
                  && (diff_y >= 33'sd0) && (diff_y < span_y);

  assign sum = {prod[48], prod} + {{18{value[31]}}, value};
  assign mag = sum[49] ? DIV_W'(-sum) : DIV_W'(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_req    = '0;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_valid) begin
          state_next = (item.mode == MODE_READ) ? S_ADDR : S_PREP;
        end
      end
      S_PREP: state_next = S_MUL;
      S_MUL:  state_next = bin_ok ? S_DIVX_GO : S_DONE;
      S_DIVX_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = INDEX_STEPS;
        div_req.dividend = {4'b0, num_x[45:0]};
        div_req.divisor  = {17'b0, span_x} << (INDEX_STEPS - 1'b1);
        state_next       = S_DIVX_WAIT;
      end
      S_DIVX_WAIT: if (div_rsp.done) state_next = S_DIVY_GO;
      S_DIVY_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = INDEX_STEPS;
        div_req.dividend = {4'b0, num_y[45:0]};
        div_req.divisor  = {17'b0, span_y} << (INDEX_STEPS - 1'b1);
        state_next       = S_DIVY_WAIT;
      end
      S_DIVY_WAIT: if (div_rsp.done) state_next = S_ADDR;
      S_ADDR:  state_next = S_READ;
      S_READ:  state_next = S_LATCH;
      S_LATCH: state_next = (cur.mode == MODE_READ) ? S_DONE : S_PROD;
      S_PROD:  state_next = S_SUM;
      S_SUM:   state_next = S_DIVM_GO;
      S_DIVM_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = MEAN_STEPS;
        div_req.dividend = div_num;
        div_req.divisor  = {32'b0, den, 1'b0} << (MEAN_STEPS - 1'b1);
        state_next       = S_DIVM_WAIT;
      end
      S_DIVM_WAIT: if (div_rsp.done) state_next = S_WRITE;
      S_WRITE: begin
        mem_we     = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || !result_stall) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign item_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == S_CLEAR) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cur <= item;
        end
      end
      S_PREP: begin
        diff_x <= {cur.x_coord[31], cur.x_coord} - {x_lower[31], x_lower};
        span_x <= {x_upper[31], x_upper} - {x_lower[31], x_lower};
        diff_y <= {y_upper[31], y_upper} - {cur.y_coord[31], cur.y_coord};
        span_y <= {y_upper[31], y_upper} - {y_lower[31], y_lower};
        value_ok <= 1'b1;
        case (value_column)
          COL_HEIGHT:     value <= cur.height;
          COL_ATTR_THREE: value <= {8'b0, cur.attr_three, 16'b0};
          COL_ATTR_FOUR:  value <= {8'b0, cur.attr_four, 16'b0};
          COL_ATTR_FIVE:  value <= {8'b0, cur.attr_five, 16'b0};
          default: begin
            value    <= 32'sd0;
            value_ok <= 1'b0;
          end
        endcase
      end
      S_MUL: begin
        num_x <= $signed({1'b0, n_x}) * diff_x;
        num_y <= $signed({1'b0, n_y}) * diff_y;
        res   <= '0;
      end
      S_DIVX_WAIT: if (div_rsp.done) col <= div_rsp.quotient[CW-1:0];
      S_DIVY_WAIT: if (div_rsp.done) row <= div_rsp.quotient[RW-1:0];
      S_ADDR: begin
        if (cur.mode == MODE_READ) begin
          addr_full <= AFW'(cur.read_index);
          addr_in   <= (32'(cur.read_index) < 32'(DEPTH));
        end else begin
          addr_full <= AFW'(row) * AFW'(MAX_COLUMNS) + AFW'(col);
          addr_in   <= 1'b1;
        end
      end
      S_LATCH: begin
        cnt  <= mem_rdata[15:0];
        mean <= mem_rdata[47:16];
        res.point_accepted <= 1'b0;
        res.cell_address   <= addr_full[15:0];
        if (addr_in) begin
          res.mean_value   <= mem_rdata[47:16];
          res.sample_count <= mem_rdata[15:0];
          res.cell_empty   <= (mem_rdata[15:0] == 16'd0);
        end else begin
          res.mean_value   <= 32'sd0;
          res.sample_count <= 16'd0;
          res.cell_empty   <= 1'b1;
        end
      end
      S_PROD: begin
        prod    <= $signed({1'b0, cnt}) * mean;
        den     <= 17'(cnt) + 17'd1;
        cnt_new <= (cnt == COUNT_MAX) ? cnt : cnt + 16'd1;
      end
      S_SUM: begin
        sum_neg <= sum[49];
        div_num <= {mag[DIV_W-2:0], 1'b0} + DIV_W'(den);
      end
      S_DIVM_WAIT: begin
        if (div_rsp.done) begin
          mean_new <= sum_neg ? -div_rsp.quotient : div_rsp.quotient;
        end
      end
      S_WRITE: begin
        res.point_accepted <= 1'b1;
        res.cell_address   <= addr_full[15:0];
        res.mean_value     <= mean_new;
        res.sample_count   <= cnt_new;
        res.cell_empty     <= 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= res;
    end
  end

  assign mem_waddr = (state == S_CLEAR) ? clr_addr : addr_full[AW-1:0];
  assign mem_wdata = (state == S_CLEAR) ? '0 : {mean_new, cnt_new};

  pgmb_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(addr_full[AW-1:0]),
    .rdata(mem_rdata)
  );

  pgmb_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

endmodule

@@ sv/pgmb_checker.sv @@
module pgmb_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input pgmb_pkg::result_t result
);
  import pgmb_pkg::*;

  // A stalled result holds until its transfer.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // The store is being cleared right after reset, so no item is taken.
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> item_stall)
    else $error("item taken during the clearing pass");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.cell_empty |->
      result.sample_count == 16'd0 && !result.point_accepted)
    else $error("empty cell with a count or an accepted point");

  a_accepted_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.point_accepted |->
      result.sample_count != 16'd0 && !result.cell_empty)
    else $error("accepted point left the cell empty");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.point_accepted && result.sample_count == 16'd0
      && !result.cell_empty |-> result.cell_address == 16'd0
      && result.mean_value == 32'sd0)
    else $error("rejected point result not cleared");

endmodule

bind point_grid_mean_binning pgmb_checker u_pgmb_checker (
  .clk         (clk),
  .rst         (rst),
  .item_stall  (item_stall),
  .result_valid(result_valid),
  .result_stall(result_stall),
  .result      (result)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import pgmb_pkg::*;

  localparam int NUM_COLS = 256;
  localparam int NUM_ROWS = 256;
  localparam int DEPTH = NUM_COLS * NUM_ROWS;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  item_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  point_grid_mean_binning i_dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the grid store and the register file.
  logic signed [31:0] mean_mirror [DEPTH];
  logic [15:0] count_mirror [DEPTH];
  logic signed [31:0] xlo, xhi, ylo, yhi;
  logic [8:0] gwidth, gheight;
  logic [2:0] vcol;

  result_t pending_results [$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_recv = 1'b0;
  longint cycles = 0;

  function automatic bit grid_bin(longint offs, longint span, longint n, output longint idx);
    longint num;
    idx = 0;
    if (span <= 0 || n <= 0) return 1'b0;
    num = n * offs;
    if (num < 0 || num >= n * span) return 1'b0;
    idx = num / span;
    return 1'b1;
  endfunction

  function automatic longint round_quot(longint num, longint den);
    if (num >= 0) return (2 * num + den) / (2 * den);
    return -((2 * (-num) + den) / (2 * den));
  endfunction

  function automatic result_t bin_point(item_t it);
    result_t r;
    longint w, h, v, col, row, cnt, nm;
    bit ok;
    int addr;
    r = '0;
    if (it.mode == MODE_READ) begin
      r.cell_address = it.read_index;
      r.mean_value = mean_mirror[it.read_index];
      r.sample_count = count_mirror[it.read_index];
      r.cell_empty = (count_mirror[it.read_index] == 0);
      return r;
    end
    w = (gwidth > NUM_COLS) ? NUM_COLS : gwidth;
    h = (gheight > NUM_ROWS) ? NUM_ROWS : gheight;
    ok = 1'b1;
    case (vcol)
      COL_HEIGHT:     v = longint'(it.height);
      COL_ATTR_THREE: v = longint'(it.attr_three) * 65536;
      COL_ATTR_FOUR:  v = longint'(it.attr_four) * 65536;
      COL_ATTR_FIVE:  v = longint'(it.attr_five) * 65536;
      default: begin
        v = 0;
        ok = 1'b0;
      end
    endcase
    ok = ok && grid_bin(longint'(it.x_coord) - longint'(xlo),
                        longint'(xhi) - longint'(xlo), w, col);
    ok = ok && grid_bin(longint'(yhi) - longint'(it.y_coord),
                        longint'(yhi) - longint'(ylo), h, row);
    if (!ok) return r;
    addr = int'(row) * NUM_COLS + int'(col);
    cnt = count_mirror[addr];
    nm = round_quot(v + cnt * longint'(mean_mirror[addr]), cnt + 1);
    mean_mirror[addr] = nm[31:0];
    if (cnt < COUNT_MAX) count_mirror[addr] = 16'(cnt + 1);
    r.point_accepted = 1'b1;
    r.cell_address = addr[15:0];
    r.mean_value = mean_mirror[addr];
    r.sample_count = count_mirror[addr];
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stall, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) result_stall <= 1'b0;
    else result_stall <= hold_recv || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result);
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result.point_accepted !== exp_r.point_accepted ||
            result.cell_address !== exp_r.cell_address ||
            result.mean_value !== exp_r.mean_value ||
            result.sample_count !== exp_r.sample_count ||
            result.cell_empty !== exp_r.cell_empty) begin
          $display("%0t: expected %p actual %p", $time, exp_r, result);
          mismatches++;
        end
      end
    end
  end

  // Valid stays high from one item to the next when there is no idle cycle between.
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    pending_results.push_back(bin_point(it));
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_X_LOWER:     xlo = val;
      REG_X_UPPER:     xhi = val;
      REG_Y_LOWER:     ylo = val;
      REG_Y_UPPER:     yhi = val;
      REG_GRID_WIDTH:  gwidth = val[8:0];
      REG_GRID_HEIGHT: gheight = val[8:0];
      default:         vcol = val[2:0];
    endcase
  endtask

  task automatic set_grid(logic [31:0] x0, logic [31:0] x1, logic [31:0] y0,
                          logic [31:0] y1, int w, int h, int c);
    drain();
    write_reg(REG_X_LOWER, x0);
    write_reg(REG_X_UPPER, x1);
    write_reg(REG_Y_LOWER, y0);
    write_reg(REG_Y_UPPER, y1);
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_VALUE_COLUMN, c);
    cfg_write <= 1'b0;
  endtask

  function automatic item_t rand_item();
    item_t it;
    it.mode = MODE_ADD;
    it.x_coord = $urandom;
    it.y_coord = $urandom;
    it.height = $urandom;
    it.attr_three = 8'($urandom);
    it.attr_four = 8'($urandom);
    it.attr_five = 8'($urandom);
    it.read_index = 16'($urandom);
    return it;
  endfunction

  // Point spread over the current span with a small margin outside.
  function automatic item_t grid_point();
    item_t it;
    longint sx, sy;
    it = rand_item();
    sx = longint'(xhi) - longint'(xlo);
    sy = longint'(yhi) - longint'(ylo);
    if (sx > 0) it.x_coord = 32'(longint'(xlo) - sx / 16 +
                                 longint'($urandom) % (sx + sx / 8 + 1));
    if (sy > 0) it.y_coord = 32'(longint'(ylo) - sy / 16 +
                                 longint'($urandom) % (sy + sy / 8 + 1));
    if ($urandom_range(3) == 0) it.height = $urandom_range(2000000) - 1000000;
    return it;
  endfunction

  function automatic item_t read_of(logic [15:0] idx);
    item_t it;
    it = rand_item();
    it.mode = MODE_READ;
    it.read_index = idx;
    return it;
  endfunction

  task automatic test_defaults();
    item_t it;
    // Corners of the default 256 by 256 grid, the edges themselves, and extremes.
    it = rand_item(); it.x_coord = 0; it.y_coord = 255; it.height = 32'h7FFFFFFF; send_item(it);
    it = rand_item(); it.x_coord = 255; it.y_coord = 1; it.height = 32'h80000000; send_item(it);
    it = rand_item(); it.x_coord = 256; it.y_coord = 100; send_item(it);
    it = rand_item(); it.x_coord = 10; it.y_coord = 0; send_item(it);
    it = rand_item(); it.x_coord = -1; it.y_coord = 100; send_item(it);
    it = rand_item(); it.x_coord = 32'h80000000; it.y_coord = 32'h7FFFFFFF; send_item(it);
    it = rand_item(); it.x_coord = 0; it.y_coord = 255; it.height = 32'h80000000; send_item(it);
    it = rand_item(); it.x_coord = 0; it.y_coord = 255; it.height = -3; send_item(it);
    send_item(read_of(16'd0));
    send_item(read_of(16'd1));
    send_item(read_of(16'hFFFF));
  endtask

  task automatic test_columns_and_bad_grids();
    item_t it;
    for (int c = 0; c < 8; c++) begin
      set_grid(-1000, 1000, -500, 700, 1 + c * 36, 256 - c * 30, c);
      repeat (3) send_item(grid_point());
    end
    set_grid(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 511, 300,
             int'(COL_ATTR_FIVE));
    it = rand_item(); it.x_coord = 32'h80000000; it.y_coord = 32'h7FFFFFFF; send_item(it);
    it = rand_item(); it.x_coord = 32'h7FFFFFFF; it.y_coord = 32'h80000000; send_item(it);
    set_grid(100, 100, 0, 50, 4, 4, int'(COL_HEIGHT));
    send_item(grid_point());
    set_grid(0, 50, 60, 10, 4, 4, int'(COL_HEIGHT));
    send_item(grid_point());
    set_grid(0, 50, 0, 50, 0, 4, int'(COL_HEIGHT));
    send_item(grid_point());
    set_grid(0, 50, 0, 50, 4, 0, int'(COL_HEIGHT));
    send_item(grid_point());
  endtask

  task automatic test_one_cell();
    item_t it;
    // A 1x1 grid keeps every point in the same cell, so the mean keeps folding in.
    set_grid(0, 16, 0, 16, 1, 1, int'(COL_ATTR_THREE));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 20; i++) begin
      it = rand_item();
      it.x_coord = 3;
      it.y_coord = 3;
      send_item(it);
    end
    send_item(read_of(16'd0));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 25) send_item(read_of($urandom_range(3) == 0 ?
                                                   16'($urandom) :
                                                   16'($urandom_range(2047))));
      else if ($urandom_range(99) < 8) send_item(rand_item());
      else send_item(grid_point());
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1'b1;
        repeat (1500) @(posedge clk);
        hold_recv = 1'b0;
      end
      test_random(20);
    join
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      mean_mirror[i] = 0;
      count_mirror[i] = 0;
    end
    xlo = 0; xhi = 256; ylo = 0; yhi = 256;
    gwidth = 256; gheight = 256; vcol = COL_HEIGHT;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_defaults();
    test_columns_and_bad_grids();
    send_idle_pct = 8;
    recv_idle_pct = 53;
    set_grid(-2000, 3000, -1000, 1500, 16, 8, int'(COL_HEIGHT));
    test_random(230);
    test_backpressure();
    send_idle_pct = 53;
    recv_idle_pct = 8;
    set_grid(-300, 300, -200, 200, 256, 256, int'(COL_ATTR_FOUR));
    test_random(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid(0, 2048, 0, 2048, 3, 5, int'(COL_HEIGHT));
    test_random(200);
    test_one_cell();
    drain();
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
